// ----- hw/rtl/piaw_pkg.sv -----
// ----------------------------------------------------------------------------
// PI controller with anti-windup: shared package
// Widths, register map, configuration and payload types, and the command
// bundle that the sequencer hands to the datapath.
// ----------------------------------------------------------------------------
package piaw_pkg;

  // Field widths.
  localparam int SAMPLE_W = 24;
  localparam int INTEG_W  = 40;
  localparam int GAIN_W   = 24;
  localparam int STEP_W   = 16;
  localparam int COUNT_W  = 32;

  // Gains and the sample period carry 16 fraction bits.
  localparam int FRAC_W = 16;
  // Width of the intermediate command and of every scaled product.
  localparam int WIDE_W = 48;

  localparam int ERR_W  = SAMPLE_W + 1;
  localparam int OPND_W = (INTEG_W > WIDE_W + 1) ? INTEG_W : WIDE_W + 1;
  localparam int CHUNK_W = 32;
  localparam int HI_W    = OPND_W - CHUNK_W;
  localparam int PROD_W  = CHUNK_W + GAIN_W;
  localparam int RND_W   = PROD_W + 1 - FRAC_W;
  // A high partial product below 2**PHI_OK_W cannot overflow the scaled result.
  localparam int PHI_OK_W = WIDE_W - 1 - FRAC_W;

  // Register map: 8-byte stride since the integrator start value is 40 bits.
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = $clog2(NUM_REGS);
  localparam int REG_LSB    = 3;
  localparam int APB_ADDR_W = REG_IDX_W + REG_LSB;
  localparam int APB_DATA_W = 64;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN     = REG_IDX_W'(0),
    REG_INTEG_GAIN    = REG_IDX_W'(1),
    REG_WINDUP_GAIN   = REG_IDX_W'(2),
    REG_DRIVE_MIN     = REG_IDX_W'(3),
    REG_DRIVE_MAX     = REG_IDX_W'(4),
    REG_STEP_TIME     = REG_IDX_W'(5),
    REG_WINDUP_ENABLE = REG_IDX_W'(6),
    REG_INTEG_START   = REG_IDX_W'(7)
  } reg_idx_e;

  // Which product the shared multiplier is working on.
  typedef enum logic [1:0] {
    OP_PROP  = 2'd0,
    OP_INTEG = 2'd1,
    OP_CORR  = 2'd2,
    OP_DELTA = 2'd3
  } op_e;

  typedef struct packed {
    logic [GAIN_W-1:0]   prop_gain;
    logic [GAIN_W-1:0]   integ_gain;
    logic [GAIN_W-1:0]   windup_gain;
    logic [SAMPLE_W-1:0] drive_min;
    logic [SAMPLE_W-1:0] drive_max;
    logic [STEP_W-1:0]   step_time;
    logic                windup_enable;
    logic [INTEG_W-1:0]  integ_start;
  } cfg_t;

  localparam cfg_t CFG_RST = '{
    prop_gain:     GAIN_W'(327680),
    integ_gain:    GAIN_W'(3277),
    windup_gain:   GAIN_W'(19661),
    drive_min:     SAMPLE_W'(0),
    drive_max:     SAMPLE_W'(184320),
    step_time:     STEP_W'(3277),
    windup_enable: 1'b1,
    integ_start:   INTEG_W'(0)
  };

  // Magnitude of the reset integrator value, saturated like the peak tracker.
  localparam logic [INTEG_W-1:0] START_ABS = CFG_RST.integ_start[INTEG_W-1] ?
      INTEG_W'(-CFG_RST.integ_start) : CFG_RST.integ_start;
  localparam logic [INTEG_W-2:0] PEAK_RST = START_ABS[INTEG_W-1] ?
      {(INTEG_W-1){1'b1}} : START_ABS[INTEG_W-2:0];

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] target_level;
    logic signed [SAMPLE_W-1:0] measured_level;
    logic                       restart;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] drive;
    logic                       saturated;
    logic signed [SAMPLE_W-1:0] lowest_drive;
    logic signed [SAMPLE_W-1:0] highest_drive;
    logic [COUNT_W-1:0]         saturated_ticks;
    logic [INTEG_W-2:0]         integ_peak;
  } out_item_t;

  // Sequencer to datapath commands.
  typedef struct packed {
    logic load;
    logic sel;
    logic mul_lo;
    logic mul_hi;
    logic mul_fin;
    logic sum;
    logic clamp;
    logic commit;
    op_e  op;
  } cmd_t;

endpackage

// ----- hw/rtl/piaw_regs.sv -----
// ----------------------------------------------------------------------------
// PI controller with anti-windup: configuration registers
// APB-style register file holding gains, limits, sample period and the
// integrator start value.
// ----------------------------------------------------------------------------
module piaw_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [piaw_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [piaw_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [piaw_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  output piaw_pkg::cfg_t                       cfg_o
);

  localparam int DW = piaw_pkg::APB_DATA_W;

  piaw_pkg::cfg_t     cfg_q, cfg_d;
  piaw_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign idx    = piaw_pkg::reg_idx_e'(paddr[piaw_pkg::APB_ADDR_W-1:piaw_pkg::REG_LSB]);
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        piaw_pkg::REG_PROP_GAIN:     cfg_d.prop_gain     = pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_INTEG_GAIN:    cfg_d.integ_gain    = pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_WINDUP_GAIN:   cfg_d.windup_gain   = pwdata[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_DRIVE_MIN:     cfg_d.drive_min     = pwdata[piaw_pkg::SAMPLE_W-1:0];
        piaw_pkg::REG_DRIVE_MAX:     cfg_d.drive_max     = pwdata[piaw_pkg::SAMPLE_W-1:0];
        piaw_pkg::REG_STEP_TIME:     cfg_d.step_time     = pwdata[piaw_pkg::STEP_W-1:0];
        piaw_pkg::REG_WINDUP_ENABLE: cfg_d.windup_enable = pwdata[0];
        piaw_pkg::REG_INTEG_START:   cfg_d.integ_start   = pwdata[piaw_pkg::INTEG_W-1:0];
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      piaw_pkg::REG_PROP_GAIN:     prdata = DW'(cfg_q.prop_gain);
      piaw_pkg::REG_INTEG_GAIN:    prdata = DW'(cfg_q.integ_gain);
      piaw_pkg::REG_WINDUP_GAIN:   prdata = DW'(cfg_q.windup_gain);
      piaw_pkg::REG_DRIVE_MIN:     prdata = DW'(cfg_q.drive_min);
      piaw_pkg::REG_DRIVE_MAX:     prdata = DW'(cfg_q.drive_max);
      piaw_pkg::REG_STEP_TIME:     prdata = DW'(cfg_q.step_time);
      piaw_pkg::REG_WINDUP_ENABLE: prdata = DW'(cfg_q.windup_enable);
      piaw_pkg::REG_INTEG_START:   prdata = DW'(cfg_q.integ_start);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= piaw_pkg::CFG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/piaw_ctrl.sv -----
// ----------------------------------------------------------------------------
// PI controller with anti-windup: sequencer
// One-hot state machine that steps one tick through the shared multiplier
// and owns the output valid flag.
// ----------------------------------------------------------------------------
module piaw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_stall_i,
  input  logic           windup_en_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output piaw_pkg::cmd_t cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_SEL     = 8'b0000_0010,
    S_MUL_LO  = 8'b0000_0100,
    S_MUL_HI  = 8'b0000_1000,
    S_MUL_FIN = 8'b0001_0000,
    S_SUM     = 8'b0010_0000,
    S_CLAMP   = 8'b0100_0000,
    S_UPDATE  = 8'b1000_0000
  } state_e;

  state_e          state_q, state_d;
  piaw_pkg::op_e   op_q, op_d;
  logic            out_valid_q, out_valid_d;
  logic            accept;
  logic            out_free;
  logic            commit;

  assign accept   = in_valid_i & (state_q == S_IDLE);
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign commit   = (state_q == S_UPDATE) & out_free;

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_SEL;
          op_d    = piaw_pkg::OP_PROP;
        end
      end
      S_SEL:    state_d = S_MUL_LO;
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_MUL_FIN;
      S_MUL_FIN: begin
        case (op_q)
          piaw_pkg::OP_PROP: begin
            op_d    = piaw_pkg::OP_INTEG;
            state_d = S_SEL;
          end
          piaw_pkg::OP_INTEG: state_d = S_SUM;
          piaw_pkg::OP_CORR: begin
            op_d    = piaw_pkg::OP_DELTA;
            state_d = S_SEL;
          end
          piaw_pkg::OP_DELTA: state_d = S_UPDATE;
          default:            state_d = S_IDLE;
        endcase
      end
      S_SUM:   state_d = S_CLAMP;
      S_CLAMP: begin
        // The correction product is skipped entirely when anti-windup is off.
        op_d    = windup_en_i ? piaw_pkg::OP_CORR : piaw_pkg::OP_DELTA;
        state_d = S_SEL;
      end
      S_UPDATE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = commit | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= piaw_pkg::OP_PROP;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  assign cmd_o.load    = accept;
  assign cmd_o.sel     = (state_q == S_SEL);
  assign cmd_o.mul_lo  = (state_q == S_MUL_LO);
  assign cmd_o.mul_hi  = (state_q == S_MUL_HI);
  assign cmd_o.mul_fin = (state_q == S_MUL_FIN);
  assign cmd_o.sum     = (state_q == S_SUM);
  assign cmd_o.clamp   = (state_q == S_CLAMP);
  assign cmd_o.commit  = commit;
  assign cmd_o.op      = op_q;

endmodule

// ----- hw/rtl/piaw_dp.sv -----
// ----------------------------------------------------------------------------
// PI controller with anti-windup: datapath
// Error, shared 32x24 multiplier with rounding and saturation, clamp,
// integrator, running metrics and the output register.
// ----------------------------------------------------------------------------
module piaw_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  piaw_pkg::cfg_t      cfg_i,
  input  piaw_pkg::cmd_t      cmd_i,
  input  piaw_pkg::in_item_t  in_data_i,
  output piaw_pkg::out_item_t out_data_o
);

  localparam int SW  = piaw_pkg::SAMPLE_W;
  localparam int IW  = piaw_pkg::INTEG_W;
  localparam int GW  = piaw_pkg::GAIN_W;
  localparam int NW  = piaw_pkg::COUNT_W;
  localparam int EW  = piaw_pkg::ERR_W;
  localparam int WW  = piaw_pkg::WIDE_W;
  localparam int OW  = piaw_pkg::OPND_W;
  localparam int CW  = piaw_pkg::CHUNK_W;
  localparam int PW  = piaw_pkg::PROD_W;
  localparam int RW  = piaw_pkg::RND_W;
  localparam int FW  = piaw_pkg::FRAC_W;
  localparam int POK = piaw_pkg::PHI_OK_W;
  localparam int UW  = OW + 1;

  localparam logic signed [WW-1:0] WIDE_MAX   = {1'b0, {(WW-1){1'b1}}};
  localparam logic signed [WW-1:0] WIDE_MIN   = {1'b1, {(WW-1){1'b0}}};
  localparam logic signed [IW-1:0] INTEG_MAX  = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] INTEG_MIN  = {1'b1, {(IW-1){1'b0}}};
  localparam logic [NW-1:0]        COUNT_MAX  = {NW{1'b1}};
  localparam logic [PW:0]          ROUND_HALF = (PW+1)'(1) << (FW - 1);

  function automatic logic [IW-2:0] mag_sat(input logic signed [IW-1:0] x);
    logic [IW-1:0] m;
    m = x[IW-1] ? IW'(-x) : IW'(x);
    return m[IW-1] ? {(IW-1){1'b1}} : m[IW-2:0];
  endfunction

  // Per-tick working registers.
  logic signed [EW-1:0] err_q;
  logic [OW-1:0]        mag_q;
  logic                 neg_q;
  logic [PW-1:0]        prod_q;
  logic [RW-1:0]        plo_rnd_q;
  logic signed [WW-1:0] prop_q;
  logic signed [WW-1:0] res_q;
  logic signed [WW-1:0] unsat_q;
  logic signed [SW-1:0] drive_q;
  logic                 sat_q;
  logic signed [WW:0]   diff_q;
  piaw_pkg::out_item_t  out_q;

  // Controller state kept across ticks.
  logic signed [IW-1:0] integ_q, integ_d;
  logic signed [SW-1:0] low_q, low_d;
  logic signed [SW-1:0] high_q, high_d;
  logic [NW-1:0]        cnt_q, cnt_d;
  logic [IW-2:0]        peak_q, peak_d;

  // Operand select and magnitude.
  logic signed [WW-1:0] corr_term;
  logic signed [OW-1:0] opnd;
  logic [OW-1:0]        opnd_mag;
  logic [GW-1:0]        gain;
  logic [CW-1:0]        mul_a;
  logic [PW-1:0]        prod_d;

  assign corr_term = cfg_i.windup_enable ? res_q : '0;

  always_comb begin
    case (cmd_i.op)
      piaw_pkg::OP_PROP:  opnd = OW'(err_q);
      piaw_pkg::OP_INTEG: opnd = OW'(integ_q);
      piaw_pkg::OP_CORR:  opnd = OW'(diff_q);
      piaw_pkg::OP_DELTA: opnd = OW'(err_q) + OW'(corr_term);
      default:            opnd = '0;
    endcase
  end

  assign opnd_mag = opnd[OW-1] ? OW'(-opnd) : OW'(opnd);

  always_comb begin
    case (cmd_i.op)
      piaw_pkg::OP_PROP:  gain = cfg_i.prop_gain;
      piaw_pkg::OP_INTEG: gain = cfg_i.integ_gain;
      piaw_pkg::OP_CORR:  gain = cfg_i.windup_gain;
      piaw_pkg::OP_DELTA: gain = GW'(cfg_i.step_time);
      default:            gain = '0;
    endcase
  end

  // Low 32 bits of the magnitude first, then the high part.
  assign mul_a  = cmd_i.mul_lo ? mag_q[CW-1:0] : CW'(mag_q[OW-1:CW]);
  assign prod_d = PW'(mul_a) * PW'(gain);

  // Recombine the halves, saturate the magnitude, restore the sign.
  logic                 phi_ovf;
  logic [WW:0]          r_sum;
  logic [WW-2:0]        r_mag;
  logic signed [WW-1:0] r_ext;
  logic signed [WW-1:0] r_val;

  assign phi_ovf = |prod_q[PW-1:POK];
  assign r_sum   = ((WW+1)'(prod_q[POK-1:0]) << FW) + (WW+1)'(plo_rnd_q);
  assign r_mag   = (phi_ovf || (r_sum > (WW+1)'(WIDE_MAX))) ? WIDE_MAX[WW-2:0]
                                                             : r_sum[WW-2:0];
  assign r_ext   = {1'b0, r_mag};
  assign r_val   = neg_q ? -r_ext : r_ext;

  // Unsaturated command.
  logic signed [WW:0]   sum_ext;
  logic signed [WW-1:0] sum_sat;

  assign sum_ext = (WW+1)'(prop_q) + (WW+1)'(res_q);
  assign sum_sat = (sum_ext > (WW+1)'(WIDE_MAX)) ? WIDE_MAX :
                   (sum_ext < (WW+1)'(WIDE_MIN)) ? WIDE_MIN : sum_ext[WW-1:0];

  // Clamp against the limits; the lower limit is tested first.
  logic signed [WW-1:0] lo_ext;
  logic signed [WW-1:0] hi_ext;
  logic                 below;
  logic                 above;
  logic signed [WW:0]   diff_lo;
  logic signed [WW:0]   diff_hi;

  assign lo_ext  = WW'($signed(cfg_i.drive_min));
  assign hi_ext  = WW'($signed(cfg_i.drive_max));
  assign below   = unsat_q < lo_ext;
  assign above   = unsat_q > hi_ext;
  assign diff_lo = (WW+1)'(lo_ext) - (WW+1)'(unsat_q);
  assign diff_hi = (WW+1)'(hi_ext) - (WW+1)'(unsat_q);

  // End-of-tick updates; res_q holds the integrator increment here.
  logic signed [UW-1:0] integ_sum;
  logic [IW-2:0]        peak_m;

  assign integ_sum = UW'(integ_q) + UW'(res_q);
  assign integ_d   = (integ_sum > UW'(INTEG_MAX)) ? INTEG_MAX :
                     (integ_sum < UW'(INTEG_MIN)) ? INTEG_MIN : integ_sum[IW-1:0];
  assign low_d     = (drive_q < low_q) ? drive_q : low_q;
  assign high_d    = (drive_q > high_q) ? drive_q : high_q;
  assign cnt_d     = (sat_q && (cnt_q != COUNT_MAX)) ? cnt_q + NW'(1) : cnt_q;
  assign peak_m    = mag_sat(integ_q);
  assign peak_d    = (peak_m > peak_q) ? peak_m : peak_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      err_q <= EW'($signed(in_data_i.target_level)) - EW'($signed(in_data_i.measured_level));
    end
    if (cmd_i.sel) begin
      mag_q <= opnd_mag;
      neg_q <= opnd[OW-1];
    end
    if (cmd_i.mul_lo || cmd_i.mul_hi) begin
      prod_q <= prod_d;
    end
    if (cmd_i.mul_hi) begin
      plo_rnd_q <= RW'(((PW+1)'(prod_q) + ROUND_HALF) >> FW);
    end
    if (cmd_i.mul_fin) begin
      if (cmd_i.op == piaw_pkg::OP_PROP) begin
        prop_q <= r_val;
      end else begin
        res_q <= r_val;
      end
    end
    if (cmd_i.sum) begin
      unsat_q <= sum_sat;
    end
    if (cmd_i.clamp) begin
      sat_q <= below | above;
      if (below) begin
        drive_q <= $signed(cfg_i.drive_min);
        diff_q  <= diff_lo;
      end else if (above) begin
        drive_q <= $signed(cfg_i.drive_max);
        diff_q  <= diff_hi;
      end else begin
        drive_q <= unsat_q[SW-1:0];
        diff_q  <= '0;
      end
    end
    if (cmd_i.commit) begin
      out_q.drive           <= drive_q;
      out_q.saturated       <= sat_q;
      out_q.lowest_drive    <= low_d;
      out_q.highest_drive   <= high_d;
      out_q.saturated_ticks <= cnt_d;
      out_q.integ_peak      <= peak_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= piaw_pkg::CFG_RST.integ_start;
      low_q   <= piaw_pkg::CFG_RST.drive_max;
      high_q  <= piaw_pkg::CFG_RST.drive_min;
      cnt_q   <= '0;
      peak_q  <= piaw_pkg::PEAK_RST;
    end else if (cmd_i.load && in_data_i.restart) begin
      integ_q <= $signed(cfg_i.integ_start);
      low_q   <= $signed(cfg_i.drive_max);
      high_q  <= $signed(cfg_i.drive_min);
      cnt_q   <= '0;
      peak_q  <= mag_sat($signed(cfg_i.integ_start));
    end else if (cmd_i.commit) begin
      integ_q <= integ_d;
      low_q   <= low_d;
      high_q  <= high_d;
      cnt_q   <= cnt_d;
      peak_q  <= peak_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ----- hw/rtl/pi_controller_anti_windup.sv -----
// ----------------------------------------------------------------------------
// PI controller with back-calculation anti-windup
// Top level: configuration registers, tick sequencer and datapath.
// ----------------------------------------------------------------------------
// Each input transfer is one control tick carrying a reference, a measured
// level (both signed Q11.12) and a restart flag; each tick produces exactly
// one result transfer with the clamped drive, a saturation flag and the
// running metrics (lowest and highest drive, saturated tick count and peak
// integrator magnitude since the last restart). The block works on one tick
// at a time and does not accept the next input transfer until the current
// tick is through its update state. All products share the single 32x24
// multiplier: the proportional term, the integral term, the back-calculation
// correction and the integrator increment each pass through it in four steps
// (operand select, low half, high half, rounding); a sum and a clamp step
// follow the integral term and a commit step ends the tick. With anti-windup
// disabled the correction is skipped. A finished result waits in the output
// register while the next tick is already accepted and computed, so a
// stalled receiver only holds the block once a second result is ready.
// Configuration registers sit on an APB-style port at an 8-byte stride and
// should only be written while no tick is in flight.
// ----------------------------------------------------------------------------
module pi_controller_anti_windup (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  // Tick input channel.
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  piaw_pkg::in_item_t              in_data_i,

  // Result channel.
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output piaw_pkg::out_item_t             out_data_o,

  // Configuration port.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [piaw_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [piaw_pkg::APB_DATA_W-1:0] pwdata,
  output logic [piaw_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);

  piaw_pkg::cfg_t cfg;
  piaw_pkg::cmd_t cmd;

  // Register file. The datapath reads the limits, gains and start value
  // directly, so a write takes effect on the next tick.
  piaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer. It accepts a tick only when idle, walks the products (four
  // with anti-windup on, three with it off) through the multiplier and holds
  // the commit until the output register is free.
  piaw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .windup_en_i (cfg.windup_enable),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Datapath. Products are rounded half away from zero and saturated to
  // 48 bits; the integrator saturates at 40 bits. Metrics are sampled with
  // the integrator value from before this tick's update.
  piaw_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- hw/rtl/piaw_checker.sv -----
// ----------------------------------------------------------------------------
// PI controller with anti-windup: port checker
// Concurrent assertions on the top-level ports, attached by a bind.
// ----------------------------------------------------------------------------
module piaw_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input piaw_pkg::out_item_t out_data_o
);

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pend_q;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign out_xfer = out_valid_o & ~out_stall_i;

  // Ticks accepted but whose result has not been transferred yet.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + 2'(in_xfer) - 2'(out_xfer);
    end
  end

  // A stalled result stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // At most one tick in work plus one result waiting.
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more ticks outstanding than the block can hold");

  // Every offered result belongs to an accepted tick.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result offered without an accepted tick");

  // The running extremes always bracket the drive they include.
  a_drive_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($signed(out_data_o.lowest_drive) <= $signed(out_data_o.drive)) &&
                    ($signed(out_data_o.drive) <= $signed(out_data_o.highest_drive)))
    else $error("drive outside the reported lowest and highest drive");

  // A saturated tick has been counted.
  a_sat_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.saturated |-> out_data_o.saturated_ticks != '0)
    else $error("saturated tick not counted");

endmodule

bind pi_controller_anti_windup piaw_checker u_piaw_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// PI controller with anti-windup: block-level testbench
// Streams control ticks into the block while randomly pausing both sides.
// A scoreboard with its own fixed-point controller predicts every result.
// Register settings change between drained phases, including all limits.
// ----------------------------------------------------------------------------
module tb;

  localparam int SW   = piaw_pkg::SAMPLE_W;
  localparam int IW   = piaw_pkg::INTEG_W;
  localparam int AW   = piaw_pkg::APB_ADDR_W;
  localparam int DW   = piaw_pkg::APB_DATA_W;
  localparam int SMIN = -(1 << (SW - 1));
  localparam int SMAX = (1 << (SW - 1)) - 1;

  // --------------------------------------------------------------------------
  // Scoreboard: a bit-accurate PI controller plus the queue of drive results
  // it expects, oldest first.
  // --------------------------------------------------------------------------
  class drive_scoreboard;
    piaw_pkg::cfg_t      regs;
    longint              integ;
    longint              lowest;
    longint              highest;
    int unsigned         sat_ticks;
    longint unsigned     peak;
    piaw_pkg::out_item_t expected_q[$];
    int                  errors;

    function new();
      regs   = piaw_pkg::CFG_RST;
      errors = 0;
      reload_state();
    endfunction

    // Product of a Q.12 value and a Q.16 gain, back to Q.12. Rounds half away
    // from zero and saturates symmetrically at the wide command width.
    function longint scale_q16(longint a, longint unsigned g);
      longint unsigned mag, phi, plo, r, limit;
      limit = (64'd1 << (piaw_pkg::WIDE_W - 1)) - 1;
      mag   = (a < 0) ? -a : a;
      phi   = (mag >> 32) * g;
      plo   = (mag & 64'hFFFF_FFFF) * g;
      if ((phi >> 31) != 0) begin
        r = limit;
      end else begin
        r = (phi << 16) + ((plo + 64'h8000) >> 16);
        if (r > limit) r = limit;
      end
      return (a < 0) ? -$signed(r) : $signed(r);
    endfunction

    function longint clamp_bits(longint x, int w);
      longint top;
      top = (longint'(1) << (w - 1)) - 1;
      if (x > top) return top;
      if (x < -top - 1) return -top - 1;
      return x;
    endfunction

    function longint unsigned abs_capped(longint x);
      longint unsigned m, cap;
      cap = (64'd1 << (IW - 1)) - 1;
      m   = (x < 0) ? -x : x;
      return (m > cap) ? cap : m;
    endfunction

    function void reload_state();
      integ     = $signed(regs.integ_start);
      lowest    = $signed(regs.drive_max);
      highest   = $signed(regs.drive_min);
      sat_ticks = 0;
      peak      = abs_capped(integ);
    endfunction

    function void copy_reg(piaw_pkg::reg_idx_e idx, logic [63:0] v);
      case (idx)
        piaw_pkg::REG_PROP_GAIN:     regs.prop_gain     = v[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_INTEG_GAIN:    regs.integ_gain    = v[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_WINDUP_GAIN:   regs.windup_gain   = v[piaw_pkg::GAIN_W-1:0];
        piaw_pkg::REG_DRIVE_MIN:     regs.drive_min     = v[SW-1:0];
        piaw_pkg::REG_DRIVE_MAX:     regs.drive_max     = v[SW-1:0];
        piaw_pkg::REG_STEP_TIME:     regs.step_time     = v[piaw_pkg::STEP_W-1:0];
        piaw_pkg::REG_WINDUP_ENABLE: regs.windup_enable = v[0];
        piaw_pkg::REG_INTEG_START:   regs.integ_start   = v[IW-1:0];
        default: ;
      endcase
    endfunction

    // One control tick: works out the drive result and queues it.
    function void note_tick(piaw_pkg::in_item_t it);
      piaw_pkg::out_item_t res;
      longint              lo, hi, err, unsat, drv, corr, delta;
      bit                  sat;
      if (it.restart) reload_state();
      lo    = $signed(regs.drive_min);
      hi    = $signed(regs.drive_max);
      err   = $signed(it.target_level);
      err   = err - $signed(it.measured_level);
      unsat = clamp_bits(scale_q16(err, regs.prop_gain) +
                         scale_q16(integ, regs.integ_gain), piaw_pkg::WIDE_W);
      if (unsat < lo) drv = lo;
      else if (unsat > hi) drv = hi;
      else drv = unsat;
      sat   = (drv != unsat);
      corr  = regs.windup_enable ? scale_q16(drv - unsat, regs.windup_gain) : 0;
      delta = scale_q16(err + corr, regs.step_time);
      if (drv < lowest) lowest = drv;
      if (drv > highest) highest = drv;
      if (sat && sat_ticks != 32'hFFFF_FFFF) sat_ticks++;
      if (abs_capped(integ) > peak) peak = abs_capped(integ);
      integ = clamp_bits(integ + delta, IW);
      res.drive           = drv[SW-1:0];
      res.saturated       = sat;
      res.lowest_drive    = lowest[SW-1:0];
      res.highest_drive   = highest[SW-1:0];
      res.saturated_ticks = sat_ticks;
      res.integ_peak      = peak[IW-2:0];
      expected_q.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(piaw_pkg::out_item_t got);
      piaw_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual drive %0d",
                 $time, got.drive);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("drive", want.drive, got.drive);
      compare_field("saturated", want.saturated, got.saturated);
      compare_field("lowest_drive", want.lowest_drive, got.lowest_drive);
      compare_field("highest_drive", want.highest_drive, got.highest_drive);
      compare_field("saturated_ticks", want.saturated_ticks, got.saturated_ticks);
      compare_field("integ_peak", want.integ_peak, got.integ_peak);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Block under test and its signals. Every input is given a value at time 0.
  // --------------------------------------------------------------------------
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  piaw_pkg::in_item_t  in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  piaw_pkg::out_item_t out_data_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [AW-1:0]       paddr;
  logic [DW-1:0]       pwdata;
  logic [DW-1:0]       prdata;
  logic                pready;

  drive_scoreboard sb;
  // When set, neither side inserts idle cycles (stretches at full rate).
  bit quiet;
  int stall_hold;

  pi_controller_anti_windup DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are taken at the rising edge at which valid is high and the
  // stall is low; the scoreboard pops the oldest expectation for each one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_data_o);
  end

  // Receiver back-pressure: runs of free cycles, short stalls and a few long
  // stalls, changed only at the falling edge.
  always @(negedge clk_i) begin : stall_gen
    int roll;
    if (stall_hold > 0) begin
      stall_hold--;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        out_stall_i <= 1'b0;
        stall_hold = $urandom_range(0, 11);
      end else if (roll < 90) begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_hold = $urandom_range(9, 39);
      end
    end
  end

  // Idle cycles the sender leaves before the next tick: mostly none or a
  // few, now and then a long gap.
  function automatic int pick_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer,
  // with valid still high so that a back-to-back tick keeps it high.
  task automatic send_tick(input piaw_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_tick(it);
    @(negedge clk_i);
  endtask

  task automatic tick(input int target, input int measured, input bit restart);
    piaw_pkg::in_item_t it;
    it.target_level   = SW'(target);
    it.measured_level = SW'(measured);
    it.restart        = restart;
    send_tick(it);
  endtask

  // Stops the sender and waits until every predicted result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  task automatic write_reg(input piaw_pkg::reg_idx_e idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(idx) << piaw_pkg::REG_LSB;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.copy_reg(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic int corner_level();
    case ($urandom_range(0, 3))
      0: return SMIN;
      1: return SMAX;
      2: return 0;
      default: return -1;
    endcase
  endfunction

  // Random tick: mostly a reference near the measurement so the loop behaves
  // like a real controller, plus full-range noise, corner values and restarts.
  function automatic piaw_pkg::in_item_t random_tick();
    piaw_pkg::in_item_t it;
    int                 roll, base;
    roll = $urandom_range(0, 99);
    if (roll < 30) begin
      it.target_level   = SW'($urandom);
      it.measured_level = SW'($urandom);
    end else if (roll < 88) begin
      base              = int'($urandom_range(0, 1 << 17)) - (1 << 16);
      it.target_level   = SW'(base);
      it.measured_level = SW'(base + int'($urandom_range(0, 1 << 11)) - (1 << 10));
    end else begin
      it.target_level   = SW'(corner_level());
      it.measured_level = SW'(corner_level());
    end
    it.restart = ($urandom_range(0, 24) == 0);
    return it;
  endfunction

  function automatic logic [63:0] pick_gain(int bits);
    int roll;
    roll = $urandom_range(0, 15);
    if (roll == 0) return '0;
    if (roll < 3) return 64'($urandom_range(0, (1 << piaw_pkg::GAIN_W) - 1));
    return 64'($urandom_range(0, (1 << bits) - 1));
  endfunction

  // New settings for a random phase; most registers are rewritten about half
  // of the time, the start value about a third, the limits always as a pair.
  task automatic shuffle_settings();
    int lo, hi, shape;
    if ($urandom_range(0, 1)) write_reg(piaw_pkg::REG_PROP_GAIN, pick_gain(20));
    if ($urandom_range(0, 1)) write_reg(piaw_pkg::REG_INTEG_GAIN, pick_gain(18));
    if ($urandom_range(0, 1)) write_reg(piaw_pkg::REG_WINDUP_GAIN, pick_gain(18));
    if ($urandom_range(0, 1)) begin
      shape = $urandom_range(0, 7);
      if (shape == 0) begin
        lo = SMIN;
        hi = SMAX;
      end else if (shape == 1) begin
        hi = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        lo = hi + int'($urandom_range(1, 1 << 16));
      end else begin
        lo = int'($urandom_range(0, 1 << 21)) - (1 << 20);
        hi = lo + int'($urandom_range(0, 1 << 18));
      end
      write_reg(piaw_pkg::REG_DRIVE_MIN, 64'(lo));
      write_reg(piaw_pkg::REG_DRIVE_MAX, 64'(hi));
    end
    if ($urandom_range(0, 1))
      write_reg(piaw_pkg::REG_STEP_TIME, 64'($urandom_range(0, 65535)));
    if ($urandom_range(0, 1))
      write_reg(piaw_pkg::REG_WINDUP_ENABLE, 64'($urandom_range(0, 1)));
    if ($urandom_range(0, 2) == 0) begin
      if ($urandom_range(0, 3) == 0)
        write_reg(piaw_pkg::REG_INTEG_START, {$urandom, $urandom});
      else
        write_reg(piaw_pkg::REG_INTEG_START,
                  64'(int'($urandom_range(0, 1 << 25)) - (1 << 24)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int random_items, phase_len, i;
    sb          = new();
    quiet       = 1'b0;
    stall_hold  = 0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset settings: zero error, small errors of both signs (the negative
    // one lands below the zero lower limit), then full-scale errors that
    // drive the command into the upper limit long enough to wind up.
    tick(0, 0, 1'b0);
    tick(4096, 0, 1'b0);
    tick(0, 4096, 1'b0);
    tick(SMAX, SMIN, 1'b0);
    tick(SMAX, SMIN, 1'b0);
    tick(SMIN, SMAX, 1'b0);
    tick(SMIN, SMIN, 1'b0);
    tick(SMAX, SMAX, 1'b0);
    tick('h555555, 'hAAAAAA, 1'b1);
    tick('hAAAAAA, 'h555555, 1'b0);

    // Plain integration without the back-calculation term.
    drain();
    write_reg(piaw_pkg::REG_WINDUP_ENABLE, 0);
    tick(SMAX, 0, 1'b1);
    tick(SMAX, 0, 1'b0);
    tick(SMIN, 0, 1'b0);

    // Every gain and the sample period at full scale, the widest limits and
    // the largest start value: the wide command and the integrator clip.
    drain();
    write_reg(piaw_pkg::REG_PROP_GAIN, 24'hFF_FFFF);
    write_reg(piaw_pkg::REG_INTEG_GAIN, 24'hFF_FFFF);
    write_reg(piaw_pkg::REG_WINDUP_GAIN, 24'hFF_FFFF);
    write_reg(piaw_pkg::REG_DRIVE_MIN, 64'(SMIN));
    write_reg(piaw_pkg::REG_DRIVE_MAX, 64'(SMAX));
    write_reg(piaw_pkg::REG_STEP_TIME, 16'hFFFF);
    write_reg(piaw_pkg::REG_INTEG_START, 64'h0000_007F_FFFF_FFFF);
    tick(SMAX, SMIN, 1'b1);
    tick(SMAX, SMIN, 1'b0);
    tick(SMIN, SMAX, 1'b0);

    // Zero gains and zero period with the most negative start value: the
    // peak magnitude caps one below the integrator range.
    drain();
    write_reg(piaw_pkg::REG_PROP_GAIN, 0);
    write_reg(piaw_pkg::REG_INTEG_GAIN, 0);
    write_reg(piaw_pkg::REG_WINDUP_GAIN, 0);
    write_reg(piaw_pkg::REG_STEP_TIME, 0);
    write_reg(piaw_pkg::REG_INTEG_START, 64'h0000_0080_0000_0000);
    tick(SMAX, SMIN, 1'b1);
    tick(100, 5, 1'b0);

    // Inverted limits: the lower limit is tested first, then the upper.
    drain();
    write_reg(piaw_pkg::REG_PROP_GAIN, 65536);
    write_reg(piaw_pkg::REG_STEP_TIME, 3277);
    write_reg(piaw_pkg::REG_WINDUP_ENABLE, 1);
    write_reg(piaw_pkg::REG_DRIVE_MIN, 1000);
    write_reg(piaw_pkg::REG_DRIVE_MAX, 64'(-1000));
    tick(0, 0, 1'b1);
    tick(5000, 0, 1'b0);
    tick(0, 5000, 1'b0);

    // Back to sensible settings before the random phases.
    drain();
    write_reg(piaw_pkg::REG_DRIVE_MIN, 64'(-200000));
    write_reg(piaw_pkg::REG_DRIVE_MAX, 200000);
    write_reg(piaw_pkg::REG_INTEG_GAIN, 3277);
    write_reg(piaw_pkg::REG_WINDUP_GAIN, 19661);
    write_reg(piaw_pkg::REG_INTEG_START, 0);

    // Random phases. Settings only change with nothing in flight; a phase
    // usually opens with a restart so the new limits seed the metrics.
    random_items = 0;
    while (random_items < 500) begin
      drain();
      shuffle_settings();
      quiet     = ($urandom_range(0, 4) == 0);
      phase_len = $urandom_range(20, 80);
      for (i = 0; i < phase_len; i++) begin
        if (i == 0 && $urandom_range(0, 3) != 0) begin
          tick(0, 0, 1'b1);
        end else begin
          send_tick(random_tick());
        end
        // Occasionally the sender holds off until all results are back.
        if ($urandom_range(0, 49) == 0) drain();
      end
      random_items += phase_len;
    end

    drain();
    quiet = 1'b0;
    repeat (40) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[pi_controller_anti_windup] OK");
    end else begin
      $display("[pi_controller_anti_windup] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("[pi_controller_anti_windup] ERROR");
    $finish;
  end

endmodule
